FILE: sv/tcc_pkg.sv
package tcc_pkg;

    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 25;
    localparam int TAB_STEP        = 4;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BLANK     = 8'd32;
    localparam logic [7:0] COLOR_RESET  = 8'd15;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL,
        S_BLANK,
        S_CLEAR,
        S_CHAR,
        S_TAB,
        S_READ,
        S_READ_WAIT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } t_req;

    typedef struct packed {
        logic [15:0] cell_res;
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_col_out;
    } t_res;

    function automatic t_state f_post(input logic [7:0] ch);
        t_state s;
        if (ch == CH_NEWLINE || ch == CH_RETURN) begin
            s = S_RESP;
        end else if (ch == CH_TAB) begin
            s = S_TAB;
        end else begin
            s = S_CHAR;
        end
        return s;
    endfunction

endpackage

FILE: sv/tcc_screen_ram.sv
module tcc_screen_ram #(
    parameter int AW    = 12,
    parameter int DEPTH = 1 << AW
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/text_console_cursor_scroll.sv
// Channel   | Signals                        | Handshake
// ----------+--------------------------------+-----------------------------------
// request   | i_req (op, ch, row, col)       | taken when start high, busy low
// result    | o_res (cell, cursor row, col)  | o_strobe high for one cycle
// config    | i_cfg_wdata (text color)       | written when i_cfg_we high
//
// Printable char: accept, write, result. Tab: accept, one blank per cycle, result.
// Return, newline without scroll, no-op: accept, result. Read: accept, read, wait, result.
// Scroll: one cell copied per cycle through the single screen RAM read and write port,
// (SCREEN_ROWS-1)*SCREEN_COLS cells, then the SCREEN_COLS cells of the bottom row blanked.
// Clear: blanks SCREEN_ROWS*SCREEN_COLS cells (2000 default); reset blanks them too, under busy.
// Results cannot be held off; each appears once, in the cycle before busy drops.
module text_console_cursor_scroll #(
    parameter int SCREEN_COLS = tcc_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tcc_pkg::SCREEN_ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  tcc_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output tcc_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);

    localparam int RW    = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int CAW   = $clog2(SCREEN_COLS);
    localparam int CCW   = $clog2(SCREEN_COLS + 1);
    localparam int AW    = RW + CAW;
    localparam int DEPTH = SCREEN_ROWS << CAW;

    localparam logic [RW-1:0]  ROW_LAST = RW'(SCREEN_ROWS - 1);
    localparam logic [CAW-1:0] COL_LAST = CAW'(SCREEN_COLS - 1);
    localparam logic [CCW-1:0] COL_END  = CCW'(SCREEN_COLS);
    localparam logic [CCW-1:0] TAB_MASK = CCW'(tcc_pkg::TAB_STEP - 1);

    tcc_pkg::t_state r_state, n_state;
    tcc_pkg::t_req   r_req, n_req;
    logic [RW-1:0]   r_crow, n_crow;
    logic [CCW-1:0]  r_ccol, n_ccol;
    logic [RW-1:0]   r_cnt_row, n_cnt_row;
    logic [CAW-1:0]  r_cnt_col, n_cnt_col;
    logic [7:0]      r_color, n_color;
    logic [7:0]      r_clr_color, n_clr_color;
    logic [15:0]     r_cell, n_cell;
    logic            r_wen, n_wen;
    logic [AW-1:0]   r_waddr, n_waddr;
    logic [15:0]     r_wdata, n_wdata;
    logic            r_wsrc, n_wsrc;

    logic [AW-1:0]   raddr;
    logic [15:0]     rdata;
    logic [15:0]     ram_wdata;
    logic            need_line;
    logic            row_at_last;
    logic            cnt_col_last;
    logic            cnt_done;
    logic            read_ok;
    logic [CCW-1:0]  ccol_inc;
    logic            tab_done;
    logic [RW-1:0]   cnt_row_adv;
    logic [CAW-1:0]  cnt_col_adv;

    assign need_line    = (i_req.ch == tcc_pkg::CH_NEWLINE)
                       || ((i_req.ch != tcc_pkg::CH_RETURN) && (r_ccol >= COL_END));
    assign row_at_last  = (r_crow == ROW_LAST);
    assign cnt_col_last = (r_cnt_col == COL_LAST);
    assign cnt_done     = cnt_col_last && (r_cnt_row == ROW_LAST);
    assign cnt_col_adv  = cnt_col_last ? '0 : r_cnt_col + CAW'(1);
    assign cnt_row_adv  = cnt_col_last ? r_cnt_row + RW'(1) : r_cnt_row;
    assign read_ok      = (32'(r_req.row) < SCREEN_ROWS) && (32'(r_req.col) < SCREEN_COLS);
    assign ccol_inc     = r_ccol + CCW'(1);
    assign tab_done     = ((ccol_inc & TAB_MASK) == '0);
    assign ram_wdata    = r_wsrc ? rdata : r_wdata;

    tcc_screen_ram #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_wen),
        .i_waddr (r_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcc_pkg::S_INIT: begin
                if (cnt_done) begin
                    n_state = tcc_pkg::S_IDLE;
                end
            end
            tcc_pkg::S_IDLE: begin
                if (start) begin
                    unique case (i_req.op)
                        tcc_pkg::OP_PUT: begin
                            if (need_line && row_at_last) begin
                                n_state = tcc_pkg::S_SCROLL;
                            end else begin
                                n_state = tcc_pkg::f_post(i_req.ch);
                            end
                        end
                        tcc_pkg::OP_READ:  n_state = tcc_pkg::S_READ;
                        tcc_pkg::OP_CLEAR: n_state = tcc_pkg::S_CLEAR;
                        tcc_pkg::OP_NOP:   n_state = tcc_pkg::S_RESP;
                    endcase
                end
            end
            tcc_pkg::S_SCROLL: begin
                if (cnt_done) begin
                    n_state = tcc_pkg::S_BLANK;
                end
            end
            tcc_pkg::S_BLANK: begin
                if (cnt_col_last) begin
                    n_state = tcc_pkg::f_post(r_req.ch);
                end
            end
            tcc_pkg::S_CLEAR: begin
                if (cnt_done) begin
                    n_state = tcc_pkg::S_RESP;
                end
            end
            tcc_pkg::S_CHAR: n_state = tcc_pkg::S_RESP;
            tcc_pkg::S_TAB: begin
                if (r_ccol >= COL_END || tab_done) begin
                    n_state = tcc_pkg::S_RESP;
                end
            end
            tcc_pkg::S_READ:      n_state = tcc_pkg::S_READ_WAIT;
            tcc_pkg::S_READ_WAIT: n_state = tcc_pkg::S_RESP;
            tcc_pkg::S_RESP:      n_state = tcc_pkg::S_IDLE;
            default:              n_state = tcc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_crow      = r_crow;
        n_ccol      = r_ccol;
        n_cnt_row   = r_cnt_row;
        n_cnt_col   = r_cnt_col;
        n_color     = i_cfg_we ? i_cfg_wdata : r_color;
        n_clr_color = r_clr_color;
        n_cell      = r_cell;
        n_wen       = 1'b0;
        n_waddr     = r_waddr;
        n_wdata     = r_wdata;
        n_wsrc      = 1'b0;
        unique case (r_state)
            tcc_pkg::S_INIT: begin
                n_wen     = 1'b1;
                n_waddr   = {r_cnt_row, r_cnt_col};
                n_wdata   = {r_clr_color, tcc_pkg::CH_BLANK};
                n_cnt_row = cnt_row_adv;
                n_cnt_col = cnt_col_adv;
            end
            tcc_pkg::S_IDLE: begin
                if (start) begin
                    n_req  = i_req;
                    n_cell = '0;
                    unique case (i_req.op)
                        tcc_pkg::OP_PUT: begin
                            if (need_line) begin
                                n_ccol = '0;
                                if (row_at_last) begin
                                    n_cnt_row = RW'(1);
                                    n_cnt_col = '0;
                                end else begin
                                    n_crow = r_crow + RW'(1);
                                end
                            end else if (i_req.ch == tcc_pkg::CH_RETURN) begin
                                n_ccol = '0;
                            end
                        end
                        tcc_pkg::OP_CLEAR: begin
                            n_clr_color = r_color;
                            n_cnt_row   = '0;
                            n_cnt_col   = '0;
                        end
                        tcc_pkg::OP_READ, tcc_pkg::OP_NOP: begin
                        end
                    endcase
                end
            end
            tcc_pkg::S_SCROLL: begin
                n_wen     = 1'b1;
                n_wsrc    = 1'b1;
                n_waddr   = {r_cnt_row - RW'(1), r_cnt_col};
                n_cnt_row = cnt_row_adv;
                n_cnt_col = cnt_col_adv;
                if (cnt_done) begin
                    n_cnt_row = ROW_LAST;
                    n_cnt_col = '0;
                end
            end
            tcc_pkg::S_BLANK: begin
                n_wen     = 1'b1;
                n_waddr   = {r_cnt_row, r_cnt_col};
                n_wdata   = {r_color, tcc_pkg::CH_BLANK};
                n_cnt_col = cnt_col_adv;
            end
            tcc_pkg::S_CLEAR: begin
                n_wen     = 1'b1;
                n_waddr   = {r_cnt_row, r_cnt_col};
                n_wdata   = {r_clr_color, tcc_pkg::CH_BLANK};
                n_cnt_row = cnt_row_adv;
                n_cnt_col = cnt_col_adv;
                if (cnt_done) begin
                    n_crow = '0;
                    n_ccol = '0;
                end
            end
            tcc_pkg::S_CHAR: begin
                n_wen   = 1'b1;
                n_waddr = {r_crow, r_ccol[CAW-1:0]};
                n_wdata = {r_color, r_req.ch};
                n_ccol  = ccol_inc;
            end
            tcc_pkg::S_TAB: begin
                if (r_ccol < COL_END) begin
                    n_wen   = 1'b1;
                    n_waddr = {r_crow, r_ccol[CAW-1:0]};
                    n_wdata = {r_color, tcc_pkg::CH_BLANK};
                    n_ccol  = ccol_inc;
                end
            end
            tcc_pkg::S_READ: begin
            end
            tcc_pkg::S_READ_WAIT: begin
                n_cell = read_ok ? rdata : '0;
            end
            tcc_pkg::S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        busy                 = (r_state != tcc_pkg::S_IDLE);
        o_strobe             = (r_state == tcc_pkg::S_RESP);
        o_res.cell_res       = r_cell;
        o_res.cursor_row_out = 5'(r_crow);
        o_res.cursor_col_out = 7'(r_ccol);
        if (r_state == tcc_pkg::S_SCROLL) begin
            raddr = {r_cnt_row, r_cnt_col};
        end else begin
            raddr = {RW'(r_req.row), CAW'(r_req.col)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcc_pkg::S_INIT;
            r_crow      <= '0;
            r_ccol      <= '0;
            r_cnt_row   <= '0;
            r_cnt_col   <= '0;
            r_color     <= tcc_pkg::COLOR_RESET;
            r_clr_color <= tcc_pkg::COLOR_RESET;
            r_wen       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_crow      <= n_crow;
            r_ccol      <= n_ccol;
            r_cnt_row   <= n_cnt_row;
            r_cnt_col   <= n_cnt_col;
            r_color     <= n_color;
            r_clr_color <= n_clr_color;
            r_wen       <= n_wen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_cell  <= n_cell;
        r_waddr <= n_waddr;
        r_wdata <= n_wdata;
        r_wsrc  <= n_wsrc;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int COLS = tcc_pkg::SCREEN_COLS_DEF;
    localparam int ROWS = tcc_pkg::SCREEN_ROWS_DEF;
    localparam int unsigned CYCLE_LIMIT = 800 * (ROWS * COLS + 16) * 3;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    tcc_pkg::t_req i_req = '0;
    logic          busy;
    logic          o_strobe;
    tcc_pkg::t_res o_res;
    logic          i_cfg_we = 1'b0;
    logic [7:0]    i_cfg_wdata = 8'h00;

    tcc_pkg::t_res status_q[$];
    logic [15:0]   scr_mem [ROWS * COLS];
    int            cur_row;
    int            cur_col;
    logic [7:0]    color_reg;

    int          n_errors = 0;
    int          n_requests = 0;
    int          n_checked = 0;
    int          n_scrolls = 0;
    int          n_reads = 0;
    bit          gaps_on = 1'b1;
    int unsigned cycle_count = 0;

    text_console_cursor_scroll uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [15:0] cell_of(logic [7:0] c);
        return {color_reg, c};
    endfunction

    function automatic void blank_all();
        for (int i = 0; i < ROWS * COLS; i++) scr_mem[i] = cell_of(tcc_pkg::CH_BLANK);
    endfunction

    function automatic void new_line();
        if (cur_row < ROWS - 1) begin
            cur_row++;
        end else begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++) scr_mem[i] = scr_mem[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++)
                scr_mem[i] = cell_of(tcc_pkg::CH_BLANK);
            n_scrolls++;
        end
        cur_col = 0;
    endfunction

    function automatic void put_at(logic [7:0] c);
        if (cur_col < COLS) begin
            scr_mem[cur_row * COLS + cur_col] = cell_of(c);
            cur_col++;
        end
    endfunction

    function automatic tcc_pkg::t_res console_step(tcc_pkg::t_req r);
        tcc_pkg::t_res res;
        int            pad;
        res = '0;
        case (r.op)
            tcc_pkg::OP_PUT: begin
                if (r.ch == tcc_pkg::CH_NEWLINE) begin
                    new_line();
                end else if (r.ch == tcc_pkg::CH_RETURN) begin
                    cur_col = 0;
                end else if (r.ch == tcc_pkg::CH_TAB) begin
                    if (cur_col >= COLS) new_line();
                    pad = tcc_pkg::TAB_STEP - (cur_col % tcc_pkg::TAB_STEP);
                    while (pad != 0 && cur_col < COLS) begin
                        put_at(tcc_pkg::CH_BLANK);
                        pad--;
                    end
                end else begin
                    if (cur_col >= COLS) new_line();
                    put_at(r.ch);
                end
            end
            tcc_pkg::OP_READ: begin
                n_reads++;
                if (int'(r.row) < ROWS && int'(r.col) < COLS)
                    res.cell_res = scr_mem[int'(r.row) * COLS + int'(r.col)];
            end
            tcc_pkg::OP_CLEAR: begin
                blank_all();
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
        res.cursor_row_out = 5'(cur_row);
        res.cursor_col_out = 7'(cur_col);
        return res;
    endfunction

    function automatic logic [7:0] rand_glyph();
        if ($urandom_range(0, 9) < 8) return 8'($urandom_range(32, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)", what, got, want,
                 n_checked);
        n_errors++;
    endtask

    always @(posedge i_clk) begin : check_results
        tcc_pkg::t_res want;
        if (i_rst_n && o_strobe) begin
            if (status_q.size() == 0) begin
                report_mismatch("result with no request pending", int'(o_res), 0);
            end else begin
                want = status_q.pop_front();
                if (o_res.cell_res !== want.cell_res)
                    report_mismatch("cell_res", int'(o_res.cell_res), int'(want.cell_res));
                if (o_res.cursor_row_out !== want.cursor_row_out)
                    report_mismatch("cursor_row_out", int'(o_res.cursor_row_out),
                                    int'(want.cursor_row_out));
                if (o_res.cursor_col_out !== want.cursor_col_out)
                    report_mismatch("cursor_col_out", int'(o_res.cursor_col_out),
                                    int'(want.cursor_col_out));
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count, status_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(tcc_pkg::t_op op, logic [7:0] ch, logic [4:0] row,
                                logic [6:0] col);
        tcc_pkg::t_req r;
        r.op  = op;
        r.ch  = ch;
        r.row = row;
        r.col = col;
        if (gaps_on && $urandom_range(0, 99) < 14) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start = 1'b1;
        i_req = r;
        do @(posedge i_clk); while (busy);
        status_q.push_back(console_step(r));
        n_requests++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic send_char(logic [7:0] ch);
        send_request(tcc_pkg::OP_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
    endtask

    task automatic read_cell(logic [4:0] row, logic [6:0] col);
        send_request(tcc_pkg::OP_READ, 8'($urandom_range(0, 255)), row, col);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (status_q.size() != 0 || busy);
    endtask

    task automatic set_color(logic [7:0] value);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        color_reg   = value;
    endtask

    task automatic test_char_extremes();
        send_char(8'h41);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h7F);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd3);
    endtask

    task automatic test_controls();
        send_char(tcc_pkg::CH_TAB);
        send_char(8'h62);
        send_char(tcc_pkg::CH_TAB);
        send_char(tcc_pkg::CH_RETURN);
        send_char(tcc_pkg::CH_NEWLINE);
        read_cell(5'd0, 7'd8);
    endtask

    task automatic test_read_bounds();
        read_cell(5'(ROWS - 1), 7'(COLS - 1));
        read_cell(5'(ROWS), 7'd0);
        read_cell(5'd0, 7'(COLS));
        read_cell(5'h1F, 7'h7F);
    endtask

    task automatic test_unused_op();
        send_request(tcc_pkg::OP_NOP, 8'hFF, 5'h1F, 7'h7F);
    endtask

    task automatic test_clear();
        set_color(8'hFF);
        send_char(8'h5A);
        send_request(tcc_pkg::OP_CLEAR, 8'hFF, 5'h1F, 7'h7F);
        read_cell(5'd1, 7'd0);
        send_char(8'h5A);
        read_cell(5'd0, 7'd0);
    endtask

    task automatic test_random_traffic(int n_items, logic [7:0] color, bit with_gaps);
        int target;
        int pick;
        int k;
        set_color(color);
        gaps_on = with_gaps;
        target = n_requests + n_items;
        while (n_requests < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                repeat ($urandom_range(5, 40)) begin
                    k = $urandom_range(0, 99);
                    if (k < 8) send_char(tcc_pkg::CH_NEWLINE);
                    else if (k < 11) send_char(tcc_pkg::CH_RETURN);
                    else if (k < 21) send_char(tcc_pkg::CH_TAB);
                    else send_char(rand_glyph());
                end
            end else if (pick < 55) begin
                // fill toward the right edge, then tab or write across it
                while (cur_col < COLS - 4) begin
                    if ($urandom_range(0, 1) != 0) send_char(tcc_pkg::CH_TAB);
                    else send_char(rand_glyph());
                end
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1) != 0) send_char(tcc_pkg::CH_TAB);
                    else send_char(rand_glyph());
                end
            end else if (pick < 67) begin
                repeat ($urandom_range(3, 30)) begin
                    if ($urandom_range(0, 4) == 0) send_char(rand_glyph());
                    else send_char(tcc_pkg::CH_NEWLINE);
                end
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 8)) begin
                    k = $urandom_range(0, 99);
                    if (k < 50)
                        read_cell(5'(cur_row), 7'($urandom_range(0, COLS - 1)));
                    else if (k < 80)
                        read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLS - 1)));
                    else
                        read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
                end
            end else if (pick < 91) begin
                send_request(tcc_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                             5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            end else if (pick < 96) begin
                send_request(tcc_pkg::OP_NOP, 8'($urandom_range(0, 255)),
                             5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            end else begin
                send_request(tcc_pkg::t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            end
        end
    endtask

    initial begin
        color_reg = tcc_pkg::COLOR_RESET;
        cur_row   = 0;
        cur_col   = 0;
        blank_all();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        wait_idle();

        test_char_extremes();
        test_controls();
        test_read_bounds();
        test_unused_op();
        test_clear();
        test_random_traffic(150, 8'h00, 1'b1);
        test_random_traffic(150, 8'($urandom_range(1, 254)), 1'b1);
        test_random_traffic(150, 8'hFF, 1'b0);
        test_random_traffic(150, tcc_pkg::COLOR_RESET, 1'b1);

        while (status_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Sent %0d requests and checked %0d results in %0d cycles", n_requests,
                 n_checked, cycle_count);
        $display("Covered %0d cell reads and %0d scrolls across four text colors", n_reads,
                 n_scrolls);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
